// ----- rtl/spms_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sparse page map store: field widths, geometry and codes.
// Used by sparse_page_map_store_unit; depends on nothing.
package spms_pkg;

  // Address geometry: 4096-byte pages, 256 pages per region
  localparam int unsigned ADDR_W   = 63;
  localparam int unsigned WITHIN_W = 12;
  localparam int unsigned PG_W     = 8;
  localparam int unsigned BASE_W   = ADDR_W - WITHIN_W - PG_W;

  // Directory and pool sizing
  localparam int unsigned REGION_SLOTS = 16;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned RCNT_W       = 5;
  localparam int unsigned POOL_PAGES   = 64;
  localparam int unsigned POOL_W       = 6;
  localparam int unsigned MAP_W        = 7;
  localparam int unsigned NZ_W         = 13;

  // Memory address widths
  localparam int unsigned MAP_AW  = SLOT_W + PG_W;
  localparam int unsigned BYTE_AW = POOL_W + WITHIN_W;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ZERO  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIR_FULL  = 2'd1,
    ST_POOL_EMPTY = 2'd2
  } status_e;

endpackage

// ----- rtl/sparse_page_map_store_unit.sv -----
`timescale 1ns / 1ps
// Sparse page map store: top level with directory, page map, page store and pool.
// Depends on spms_pkg.

// One byte access per transaction. After reset the block runs a clearing
// pass (one page-store byte per cycle, the page map cleared alongside) and
// accepts nothing until it ends. A transaction then walks directory
// compare, page map read, page-store read, read-modify-write and the output
// load. When the page store is touched it passes the map, page, RMW and
// done states; when the page is unmapped or the pool is empty, the map,
// page and done states; for an unused kind, a full directory, or a read or
// zero of an unmapped region, only the map and done states. The next
// transaction is taken the cycle after the result loads. The page map and
// page store are single-port-write memories with registered reads; one
// transaction is in flight at a time, so their writes always land before
// the next transaction reads them. A finished result waits in the output
// register while the next transaction is taken; a new result stalls in the
// output state until the waiting one is accepted.
module sparse_page_map_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [62:0] offset_i,
  input  logic [7:0]  data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  status_o
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_MAP  = 6'b000100,
    S_PAGE = 6'b001000,
    S_RMW  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Latched transaction
  logic [1:0]                    kind_q;
  logic [spms_pkg::BASE_W-1:0]   base_q;
  logic [spms_pkg::PG_W-1:0]     pg_q;
  logic [spms_pkg::WITHIN_W-1:0] within_q;
  logic [7:0]                    data_q;
  logic [spms_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [spms_pkg::POOL_W-1:0]   pool_q, pool_d;
  logic                          fresh_q, fresh_d;
  logic [7:0]                    rd_res_q, rd_res_d;
  logic [1:0]                    st_res_q, st_res_d;

  // Directory and pool bookkeeping
  logic [spms_pkg::BASE_W-1:0]   region_base_q [spms_pkg::REGION_SLOTS];
  logic [spms_pkg::RCNT_W-1:0]   region_cnt_q, region_cnt_d;
  logic                          dir_we;
  logic [spms_pkg::POOL_PAGES-1:0] free_q, free_d;
  logic [spms_pkg::BYTE_AW-1:0]  clr_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] read_data_q;
  logic [1:0] status_q;

  // Memories
  logic [spms_pkg::MAP_W-1:0]  map_mem [2**spms_pkg::MAP_AW];
  logic                        map_we;
  logic [spms_pkg::MAP_AW-1:0] map_waddr, map_raddr;
  logic [spms_pkg::MAP_W-1:0]  map_wdata, map_rdata_q;

  logic [7:0]                   byte_mem [2**spms_pkg::BYTE_AW];
  logic                         byte_we;
  logic [spms_pkg::BYTE_AW-1:0] byte_waddr, byte_raddr;
  logic [7:0]                   byte_wdata, byte_rdata_q;

  logic [spms_pkg::NZ_W-1:0]   nz_mem [spms_pkg::POOL_PAGES];
  logic                        nz_we;
  logic [spms_pkg::POOL_W-1:0] nz_raddr;
  logic [spms_pkg::NZ_W-1:0]   nz_wdata, nz_rdata_q;

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[byte_waddr] <= byte_wdata;
    byte_rdata_q <= byte_mem[byte_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nz_we) nz_mem[pool_d] <= nz_wdata;
    nz_rdata_q <= nz_mem[nz_raddr];
  end

  // Directory search over the used slots
  logic                        hit;
  logic [spms_pkg::SLOT_W-1:0] hit_slot;
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < spms_pkg::REGION_SLOTS; i++) begin
      if (!hit && (spms_pkg::RCNT_W'(i) < region_cnt_q) && (region_base_q[i] == base_q)) begin
        hit      = 1'b1;
        hit_slot = spms_pkg::SLOT_W'(i);
      end
    end
  end

  // Lowest free pool page
  logic                        any_free;
  logic [spms_pkg::POOL_W-1:0] new_page;
  always_comb begin
    any_free = 1'b0;
    new_page = '0;
    for (int i = 0; i < spms_pkg::POOL_PAGES; i++) begin
      if (!any_free && free_q[i]) begin
        any_free = 1'b1;
        new_page = spms_pkg::POOL_W'(i);
      end
    end
  end

  logic [spms_pkg::SLOT_W-1:0] slot_sel;
  logic [spms_pkg::POOL_W-1:0] pool_sel;
  logic [spms_pkg::NZ_W-1:0]   nz_old, nz_new;
  logic [7:0]                  old_byte;

  assign slot_sel   = (state_q == S_MAP) ?
                      (hit ? hit_slot : region_cnt_q[spms_pkg::SLOT_W-1:0]) : slot_q;
  assign pool_sel   = (map_rdata_q != '0) ?
                      spms_pkg::POOL_W'(map_rdata_q - spms_pkg::MAP_W'(1)) : new_page;
  assign map_raddr  = {slot_sel, pg_q};
  assign byte_raddr = {pool_sel, within_q};
  assign nz_raddr   = pool_sel;
  assign old_byte   = byte_rdata_q;
  assign nz_old     = fresh_q ? '0 : nz_rdata_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    pool_d       = pool_q;
    fresh_d      = fresh_q;
    rd_res_d     = rd_res_q;
    st_res_d     = st_res_q;
    region_cnt_d = region_cnt_q;
    dir_we       = 1'b0;
    free_d       = free_q;
    map_we       = 1'b0;
    map_waddr    = {slot_q, pg_q};
    map_wdata    = '0;
    byte_we      = 1'b0;
    byte_waddr   = {pool_q, within_q};
    byte_wdata   = '0;
    nz_we        = 1'b0;
    nz_wdata     = '0;
    nz_new       = nz_old;

    unique case (state_q)
      S_CLR: begin
        byte_we    = 1'b1;
        byte_waddr = clr_q;
        map_we     = (clr_q[spms_pkg::BYTE_AW-1:spms_pkg::MAP_AW] == '0);
        map_waddr  = clr_q[spms_pkg::MAP_AW-1:0];
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        rd_res_d = '0;
        st_res_d = spms_pkg::ST_OK;
        if (in_valid_i) state_d = S_MAP;
      end
      S_MAP: begin
        if (kind_q == spms_pkg::KIND_NONE) begin
          state_d = S_DONE;
        end else if (hit) begin
          slot_d  = hit_slot;
          state_d = S_PAGE;
        end else if (kind_q == spms_pkg::KIND_WRITE) begin
          if (region_cnt_q == spms_pkg::RCNT_W'(spms_pkg::REGION_SLOTS)) begin
            st_res_d = spms_pkg::ST_DIR_FULL;
            state_d  = S_DONE;
          end else begin
            dir_we       = 1'b1;
            slot_d       = region_cnt_q[spms_pkg::SLOT_W-1:0];
            region_cnt_d = region_cnt_q + spms_pkg::RCNT_W'(1);
            state_d      = S_PAGE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_PAGE: begin
        pool_d  = pool_sel;
        fresh_d = 1'b0;
        if (map_rdata_q != '0) begin
          state_d = S_RMW;
        end else if (kind_q == spms_pkg::KIND_WRITE) begin
          if (any_free) begin
            free_d[new_page] = 1'b0;
            map_we    = 1'b1;
            map_wdata = spms_pkg::MAP_W'(new_page) + spms_pkg::MAP_W'(1);
            fresh_d   = 1'b1;
            state_d   = S_RMW;
          end else begin
            st_res_d = spms_pkg::ST_POOL_EMPTY;
            state_d  = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_RMW: begin
        state_d = S_DONE;
        case (kind_q)
          spms_pkg::KIND_READ: rd_res_d = old_byte;
          spms_pkg::KIND_WRITE: begin
            if (old_byte == '0 && data_q != '0) begin
              nz_new = nz_old + spms_pkg::NZ_W'(1);
            end else if (old_byte != '0 && data_q == '0 && nz_old != '0) begin
              nz_new = nz_old - spms_pkg::NZ_W'(1);
            end
            byte_we    = 1'b1;
            byte_wdata = data_q;
            nz_we      = 1'b1;
            nz_wdata   = nz_new;
          end
          spms_pkg::KIND_ZERO: begin
            if (old_byte != '0 && nz_old != '0) nz_new = nz_old - spms_pkg::NZ_W'(1);
            byte_we  = 1'b1;
            nz_we    = 1'b1;
            nz_wdata = nz_new;
            // Page holds no nonzero byte: unmap it and return it to the pool
            if (nz_new == '0) begin
              free_d[pool_q] = 1'b1;
              map_we         = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_CLR;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign status_o    = status_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      region_cnt_q <= '0;
      free_q       <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      region_cnt_q <= region_cnt_d;
      free_q       <= free_d;
      if (state_q == S_CLR) clr_q <= clr_q + spms_pkg::BYTE_AW'(1);
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    pool_q   <= pool_d;
    fresh_q  <= fresh_d;
    rd_res_q <= rd_res_d;
    st_res_q <= st_res_d;
    if (dir_we) region_base_q[region_cnt_q[spms_pkg::SLOT_W-1:0]] <= base_q;
    if (in_valid_i && in_ready_o) begin
      kind_q   <= kind_i;
      base_q   <= offset_i[spms_pkg::ADDR_W-1:spms_pkg::ADDR_W-spms_pkg::BASE_W];
      pg_q     <= offset_i[spms_pkg::WITHIN_W+spms_pkg::PG_W-1:spms_pkg::WITHIN_W];
      within_q <= offset_i[spms_pkg::WITHIN_W-1:0];
      data_q   <= data_in_i;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      read_data_q <= rd_res_q;
      status_q    <= st_res_q;
    end
  end

endmodule

// ----- tb/tb_sparse_page_map_store_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sparse_page_map_store_unit: byte reads, writes and
// zero accesses against a software copy of the directory, page map and pool.
// Depends on spms_pkg and the unit RTL.
module tb_sparse_page_map_store_unit;

  localparam int unsigned N_RANDOM  = 650;
  localparam int unsigned N_BASES   = 20;
  localparam longint      MAX_CYCLES = 1_200_000;

  typedef struct packed {
    spms_pkg::kind_e kind;
    logic [62:0]     offset;
    logic [7:0]      data;
  } access_t;

  typedef struct packed {
    logic [7:0]        rd;
    spms_pkg::status_e st;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [62:0] offset_i;
  logic [7:0]  data_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  read_data_o;
  logic [1:0]  status_o;

  sparse_page_map_store_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .offset_i    (offset_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the store state
  logic [spms_pkg::BASE_W-1:0] region_tag [spms_pkg::REGION_SLOTS];
  int unsigned       region_cnt;
  logic [spms_pkg::MAP_W-1:0]  page_map_q [spms_pkg::REGION_SLOTS*256];
  logic [7:0]        pool_bytes [spms_pkg::POOL_PAGES*4096];
  bit                pool_free  [spms_pkg::POOL_PAGES];
  int unsigned       pool_nz    [spms_pkg::POOL_PAGES];

  access_t     pending_q [$];
  answer_t     answer_q  [$];
  int unsigned errors;
  int unsigned n_ok, n_full, n_empty, n_reads_hit;
  longint      cycles;
  logic [spms_pkg::BASE_W-1:0] bases [N_BASES];

  function automatic access_t mk(input spms_pkg::kind_e k, input logic [62:0] off,
                                 input logic [7:0] d);
    access_t a;
    a.kind = k;
    a.offset = off;
    a.data = d;
    return a;
  endfunction

  // Apply one access to the shadow state and return the answer it must give
  function automatic answer_t store_access(input access_t a);
    logic [spms_pkg::BASE_W-1:0] tag;
    int unsigned pg, byte_off, mi, pool, bi;
    int slot, np;
    answer_t ans;
    tag      = a.offset[62:20];
    pg       = {24'd0, a.offset[19:12]};
    byte_off = {20'd0, a.offset[11:0]};
    ans.rd = '0;
    ans.st = spms_pkg::ST_OK;
    slot   = -1;
    for (int i = 0; i < region_cnt; i++)
      if (slot < 0 && region_tag[i] == tag) slot = i;
    case (a.kind)
      spms_pkg::KIND_READ: begin
        if (slot >= 0) begin
          mi = slot * 256 + pg;
          if (page_map_q[mi] != 0) begin
            pool   = page_map_q[mi] - 1;
            ans.rd = pool_bytes[pool*4096 + byte_off];
            if (ans.rd != 0) n_reads_hit++;
          end
        end
      end
      spms_pkg::KIND_WRITE: begin
        if (slot < 0) begin
          if (region_cnt >= spms_pkg::REGION_SLOTS) begin
            ans.st = spms_pkg::ST_DIR_FULL;
          end else begin
            slot = int'(region_cnt);
            region_tag[slot] = tag;
            for (int p = 0; p < 256; p++) page_map_q[slot*256 + p] = '0;
            region_cnt++;
          end
        end
        if (slot >= 0) begin
          mi = slot * 256 + pg;
          if (page_map_q[mi] == 0) begin
            np = -1;
            for (int i = 0; i < spms_pkg::POOL_PAGES; i++)
              if (np < 0 && pool_free[i]) np = i;
            if (np < 0) begin
              ans.st = spms_pkg::ST_POOL_EMPTY;
            end else begin
              pool_free[np] = 1'b0;
              pool_nz[np]   = 0;
              for (int b = 0; b < 4096; b++) pool_bytes[np*4096 + b] = '0;
              page_map_q[mi] = spms_pkg::MAP_W'(np + 1);
            end
          end
          if (page_map_q[mi] != 0) begin
            pool = page_map_q[mi] - 1;
            bi   = pool * 4096 + byte_off;
            if (pool_bytes[bi] == 0 && a.data != 0) pool_nz[pool]++;
            else if (pool_bytes[bi] != 0 && a.data == 0 && pool_nz[pool] > 0)
              pool_nz[pool]--;
            pool_bytes[bi] = a.data;
          end
        end
      end
      spms_pkg::KIND_ZERO: begin
        if (slot >= 0) begin
          mi = slot * 256 + pg;
          if (page_map_q[mi] != 0) begin
            pool = page_map_q[mi] - 1;
            bi   = pool * 4096 + byte_off;
            if (pool_bytes[bi] != 0 && pool_nz[pool] > 0) pool_nz[pool]--;
            pool_bytes[bi] = '0;
            if (pool_nz[pool] == 0) begin
              pool_free[pool] = 1'b1;
              page_map_q[mi]  = '0;
            end
          end
        end
      end
      default: ;
    endcase
    case (ans.st)
      spms_pkg::ST_DIR_FULL:   n_full++;
      spms_pkg::ST_POOL_EMPTY: n_empty++;
      default:                 n_ok++;
    endcase
    return ans;
  endfunction

  // Idle length per transaction; transactions 40 to 79 of every 120 run with no idle
  function automatic int unsigned draw_gap(input int unsigned seq);
    if ((seq / 40) % 3 == 1) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Input driver
  int unsigned in_gap, in_seq;
  always @(posedge clk_i or negedge rst_ni) begin
    access_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i     <= spms_pkg::KIND_READ;
      offset_i   <= '0;
      data_in_i  <= '0;
      in_gap     <= 0;
      in_seq     <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        answer_q.push_back(store_access(mk(spms_pkg::kind_e'(kind_i), offset_i,
                                           data_in_i)));
      end
      if (in_gap > 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        kind_i     <= nxt.kind;
        offset_i   <= nxt.offset;
        data_in_i  <= nxt.data;
        in_valid_i <= 1'b1;
        in_gap     <= draw_gap(in_seq);
        in_seq     <= in_seq + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor with random back-pressure
  int unsigned out_stall, out_seq;
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    int unsigned gap;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
      out_seq     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (answer_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result rd=%0h status=%0d", $time,
                   read_data_o, status_o);
        end else begin
          want = answer_q.pop_front();
          if (read_data_o !== want.rd) begin
            errors++;
            $display("%0t: read_data expected %0h actual %0h", $time,
                     want.rd, read_data_o);
          end
          if (status_o !== want.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.st, status_o);
          end
        end
        gap = draw_gap(out_seq + 17);
        out_seq <= out_seq + 1;
        out_stall <= gap;
        out_ready_i <= (gap == 0);
      end else if (out_stall > 0) begin
        out_stall   <= out_stall - 1;
        out_ready_i <= (out_stall == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog; the limit covers the clearing pass after reset
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Addresses cluster on a few regions and pages so accesses hit each other
  function automatic logic [62:0] pick_offset();
    logic [spms_pkg::BASE_W-1:0] b;
    logic [7:0]  pg;
    logic [11:0] w;
    b  = bases[$urandom_range(0, N_BASES-1)];
    pg = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    case ($urandom_range(0, 4))
      0: w = 12'd0;
      1: w = 12'd1;
      2: w = 12'hFFF;
      3: w = 12'($urandom_range(0, 7));
      default: w = 12'($urandom);
    endcase
    return {b, pg, w};
  endfunction

  initial begin
    int unsigned r;
    spms_pkg::kind_e k;
    logic [7:0] d;
    errors = 0; cycles = 0;
    n_ok = 0; n_full = 0; n_empty = 0; n_reads_hit = 0;
    region_cnt = 0;
    for (int i = 0; i < spms_pkg::REGION_SLOTS*256; i++) page_map_q[i] = '0;
    for (int i = 0; i < spms_pkg::POOL_PAGES*4096; i++) pool_bytes[i] = '0;
    for (int i = 0; i < spms_pkg::POOL_PAGES; i++) begin
      pool_free[i] = 1'b1;
      pool_nz[i]   = 0;
    end
    bases[0] = '0;
    bases[1] = '1;
    for (int i = 2; i < N_BASES; i++) bases[i] = spms_pkg::BASE_W'({$urandom, $urandom});

    // Directed: extremes, every kind, zero writes, freeing and the unused kind
    pending_q.push_back(mk(spms_pkg::KIND_READ,  63'd0, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_ZERO,  63'd0, 8'hFF));
    pending_q.push_back(mk(spms_pkg::KIND_WRITE, '1, 8'hFF));
    pending_q.push_back(mk(spms_pkg::KIND_READ,  '1, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_NONE,  '1, 8'hAA));
    pending_q.push_back(mk(spms_pkg::KIND_WRITE, 63'd5, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_READ,  63'd5, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_ZERO,  63'd5, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_WRITE, 63'd7, 8'h5A));
    pending_q.push_back(mk(spms_pkg::KIND_WRITE, 63'd8, 8'hA5));
    pending_q.push_back(mk(spms_pkg::KIND_ZERO,  63'd7, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_READ,  63'd8, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_ZERO,  63'd8, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_READ,  63'd8, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_WRITE, 63'h2AAA_AAAA_AAAA_AAAA, 8'h55));
    pending_q.push_back(mk(spms_pkg::KIND_WRITE, 63'h5555_5555_5555_5555, 8'hAA));
    pending_q.push_back(mk(spms_pkg::KIND_READ,  63'h2AAA_AAAA_AAAA_AAAA, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_ZERO,  '1, 8'h00));
    pending_q.push_back(mk(spms_pkg::KIND_READ,  '1, 8'h00));

    // Random mix, weighted to writes so the directory and pool fill up
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      k = spms_pkg::KIND_WRITE;
      else if (r < 70) k = spms_pkg::KIND_READ;
      else if (r < 95) k = spms_pkg::KIND_ZERO;
      else             k = spms_pkg::KIND_NONE;
      d = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom);
      pending_q.push_back(mk(k, pick_offset(), d));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i);
    wait (answer_q.size() == 0);
    repeat (30) @(posedge clk_i);
    if (answer_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, answer_q.size());
    end

    $display("Ran %0d accesses: %0d ok, %0d directory full, %0d pool empty,",
             in_seq, n_ok, n_full, n_empty);
    $display("  %0d regions mapped, %0d reads returned stored data",
             region_cnt, n_reads_hit);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/spms_pkg.sv
rtl/sparse_page_map_store_unit.sv
tb/tb_sparse_page_map_store_unit.sv
